>>> rtl/gate_position_tracker_top_macros.svh
// Assertion macros for the gate position tracker checker.
// No dependencies; included by the checker file.
`ifndef GATE_POSITION_TRACKER_TOP_MACROS_SVH
`define GATE_POSITION_TRACKER_TOP_MACROS_SVH

// same-cycle implication, reset masks the check
`define GPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gate tracker check failed");

// next-cycle implication
`define GPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gate tracker check failed");

`endif

>>> rtl/gpt_pkg.sv
// Shared types, codes and constants of the gate position tracker.
// No dependencies; used by every other file of the block but the macros header.
`timescale 1ns / 1ps

package gpt_pkg;

	localparam int TIME_W     = 32;
	localparam int POS_W      = 7;
	localparam int TRAVEL_W   = 8;
	localparam int MINUPD_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIVISOR_W  = 12;  // 10 * 255 fits in 12 bits
	localparam int DIV_STEPS  = TIME_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic [POS_W-1:0] POS_FULL = POS_W'(100);
	localparam logic [POS_W-1:0] POS_ZERO = '0;

	// travel time reset values, minimum update interval reset value
	localparam logic [TRAVEL_W-1:0] UP_TRAVEL_RST   = TRAVEL_W'(13);
	localparam logic [TRAVEL_W-1:0] DOWN_TRAVEL_RST = TRAVEL_W'(19);
	localparam logic [MINUPD_W-1:0] MIN_UPDATE_RST  = MINUPD_W'(200);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UP_TRAVEL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_TRAVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_UPDATE  = 2'd2;

	typedef enum logic [2:0] {
		MODE_POLL,
		MODE_OPEN,
		MODE_CLOSE,
		MODE_STOP,
		MODE_LIGHT_ON,
		MODE_LIGHT_OFF
	} mode_t;

	typedef enum logic [2:0] {
		G_OPEN,
		G_OPENING,
		G_CLOSED,
		G_CLOSING,
		G_STOPPED,
		G_UNKNOWN
	} gate_mode_t;

	typedef enum logic [1:0] {
		L_OFF,
		L_ON,
		L_UNKNOWN
	} light_mode_t;

	localparam logic [1:0] RELAY_NONE  = 2'd0;
	localparam logic [1:0] RELAY_OPEN  = 2'd1;
	localparam logic [1:0] RELAY_CLOSE = 2'd2;
	localparam logic [1:0] RELAY_STOP  = 2'd3;

	localparam logic [1:0] DRIVE_NONE = 2'd0;
	localparam logic [1:0] DRIVE_OFF  = 2'd1;
	localparam logic [1:0] DRIVE_ON   = 2'd2;

	typedef struct packed {
		logic [2:0]        mode;
		logic              force_req;
		logic              open_switch;
		logic              closed_switch;
		logic              light_sense;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [2:0]       gate_report;
		logic [POS_W-1:0] position_pct;
		logic             state_publish;
		logic             position_publish;
		logic             light_report;
		logic             light_publish;
		logic [1:0]       relay_fire;
		logic [1:0]       light_drive;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} gpt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic needs_div;
	} gpt_sts_t;

endpackage

>>> rtl/gpt_if.sv
// Request channel interfaces of the gate position tracker.
// Depends on gpt_pkg for field widths.
`timescale 1ns / 1ps

interface gpt_in_if import gpt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        mode;
	logic              force_req;
	logic              open_switch;
	logic              closed_switch;
	logic              light_sense;
	logic [TIME_W-1:0] now_ms;

	modport source(output valid, mode, force_req, open_switch, closed_switch,
		light_sense, now_ms, input ready);
	modport sink(input valid, mode, force_req, open_switch, closed_switch,
		light_sense, now_ms, output ready);
endinterface

interface gpt_out_if import gpt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [2:0]       gate_report;
	logic [POS_W-1:0] position_pct;
	logic             state_publish;
	logic             position_publish;
	logic             light_report;
	logic             light_publish;
	logic [1:0]       relay_fire;
	logic [1:0]       light_drive;

	modport source(output valid, gate_report, position_pct, state_publish,
		position_publish, light_report, light_publish, relay_fire, light_drive,
		input ready);
	modport sink(input valid, gate_report, position_pct, state_publish,
		position_publish, light_report, light_publish, relay_fire, light_drive,
		output ready);
endinterface

>>> rtl/gpt_dp.sv
// Datapath: config registers, tracker state, restoring divider, result register.
// Depends on gpt_pkg; sequenced by gpt_ctrl.
`timescale 1ns / 1ps

module gpt_dp import gpt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gpt_cmd_t              cmd,
	output gpt_sts_t              sts,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  item_t                 item,
	output result_t               res
);

	logic [TRAVEL_W-1:0]  up_q, down_q;
	logic [MINUPD_W-1:0]  min_q;

	gate_mode_t           gm_q;
	logic [POS_W-1:0]     pos_q;
	logic [TIME_W-1:0]    lmt_q;
	light_mode_t          lm_q;

	item_t                it_q;
	logic [TIME_W-1:0]    elapsed_q;
	logic [DIVISOR_W-1:0] div10_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [TIME_W-1:0]    dq_q;     // dividend shifts out the top, quotient in the bottom
	result_t              res_q;

	gate_mode_t           g1;       // gate mode after the between-switch transition
	logic                 at_open, at_closed, between, moving;
	logic [TRAVEL_W-1:0]  sec, sec_nz;
	logic [DIVISOR_W-1:0] div10;
	logic [DIVISOR_W:0]   rem_sh;
	logic                 rem_ge;
	logic [POS_W-1:0]     delta;
	logic [POS_W:0]       pos_sum;
	logic                 sf;

	gate_mode_t           sy_gm, gm_n;
	logic [POS_W-1:0]     sy_pos, pos_n;
	logic [TIME_W-1:0]    sy_lmt, lmt_n;
	light_mode_t          sy_lm, lm_n;
	logic                 sy_ps, sy_pp, sy_pl;
	logic                 ps, pp, pl;
	logic [1:0]           relay, drive;

	assign at_open   = !it_q.open_switch && it_q.closed_switch;
	assign at_closed = it_q.open_switch && !it_q.closed_switch;
	assign between   = !at_open && !at_closed;

	always_comb begin
		case (gm_q)
			G_OPEN, G_OPENING:   g1 = G_OPENING;
			G_CLOSED, G_CLOSING: g1 = G_CLOSING;
			G_UNKNOWN:           g1 = G_STOPPED;
			default:             g1 = gm_q;
		endcase
	end

	assign moving = (g1 == G_OPENING) || (g1 == G_CLOSING);
	assign sts.needs_div = (it_q.mode == MODE_POLL) && between && moving;

	// divisor = 10 * travel seconds; elapsed*100/(sec*1000) reduces to elapsed/(10*sec)
	assign sec    = (g1 == G_OPENING) ? up_q : down_q;
	assign sec_nz = (sec == '0) ? TRAVEL_W'(1) : sec;
	assign div10  = DIVISOR_W'({sec_nz, 3'b000}) + DIVISOR_W'({sec_nz, 1'b0});

	assign rem_sh = {rem_q, dq_q[TIME_W-1]};
	assign rem_ge = rem_sh >= {1'b0, div10_q};

	// quotient saturates; position never moves more than 100 anyway
	assign delta = (|dq_q[TIME_W-1:POS_W]) ? {POS_W{1'b1}} : dq_q[POS_W-1:0];
	assign pos_sum = {1'b0, pos_q} + {1'b0, delta};

	assign sf = (it_q.mode == MODE_POLL) ? it_q.force_req : 1'b1;

	// resync from switches and time
	always_comb begin
		sy_lm  = it_q.light_sense ? L_ON : L_OFF;
		sy_pl  = sf || (lm_q != sy_lm);
		sy_gm  = g1;
		sy_pos = pos_q;
		sy_lmt = lmt_q;
		sy_pp  = sf;
		sy_ps  = sf || (gm_q != g1);
		if (!between) begin
			sy_gm  = at_open ? G_OPEN : G_CLOSED;
			sy_pos = at_open ? POS_FULL : POS_ZERO;
			sy_lmt = it_q.now_ms;
			sy_ps  = sf || (gm_q != sy_gm);
			sy_pp  = sy_ps;
		end else if (moving && (elapsed_q >= TIME_W'(min_q) || sf)
				&& (delta != '0 || sf)) begin
			if (g1 == G_OPENING) begin
				sy_pos = (pos_sum >= (POS_W+1)'(POS_FULL)) ? POS_FULL : pos_sum[POS_W-1:0];
			end else begin
				sy_pos = (delta >= pos_q) ? POS_ZERO : pos_q - delta;
			end
			sy_lmt = it_q.now_ms;
			sy_pp  = 1'b1;
		end
	end

	always_comb begin
		gm_n  = gm_q;
		pos_n = pos_q;
		lmt_n = lmt_q;
		lm_n  = lm_q;
		ps    = 1'b0;
		pp    = 1'b0;
		pl    = 1'b0;
		relay = RELAY_NONE;
		drive = DRIVE_NONE;
		case (mode_t'(it_q.mode))
			MODE_POLL: begin
				gm_n  = sy_gm;
				pos_n = sy_pos;
				lmt_n = sy_lmt;
				lm_n  = sy_lm;
				ps    = sy_ps;
				pp    = sy_pp;
				pl    = sy_pl;
			end
			MODE_OPEN, MODE_CLOSE, MODE_STOP: begin
				case (mode_t'(it_q.mode))
					MODE_OPEN:  relay = RELAY_OPEN;
					MODE_CLOSE: relay = RELAY_CLOSE;
					default:    relay = RELAY_STOP;
				endcase
				if (between) begin
					ps = 1'b1;
					case (mode_t'(it_q.mode))
						MODE_OPEN: begin
							gm_n  = G_OPENING;
							lmt_n = it_q.now_ms;
						end
						MODE_CLOSE: begin
							gm_n  = G_CLOSING;
							lmt_n = it_q.now_ms;
						end
						default: gm_n = G_STOPPED;  // stop keeps the move time
					endcase
				end else begin
					gm_n  = sy_gm;
					pos_n = sy_pos;
					lmt_n = sy_lmt;
					lm_n  = sy_lm;
					ps    = sy_ps;
					pp    = sy_pp;
					pl    = sy_pl;
				end
			end
			MODE_LIGHT_ON: begin
				drive = DRIVE_ON;
				lm_n  = L_ON;
				pl    = 1'b1;
			end
			MODE_LIGHT_OFF: begin
				drive = DRIVE_OFF;
				lm_n  = L_OFF;
				pl    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q   <= UP_TRAVEL_RST;
			down_q <= DOWN_TRAVEL_RST;
			min_q  <= MIN_UPDATE_RST;
			gm_q   <= G_UNKNOWN;
			pos_q  <= POS_ZERO;
			lmt_q  <= '0;
			lm_q   <= L_UNKNOWN;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_UP_TRAVEL:   up_q   <= cfg_data[TRAVEL_W-1:0];
					REG_DOWN_TRAVEL: down_q <= cfg_data[TRAVEL_W-1:0];
					REG_MIN_UPDATE:  min_q  <= cfg_data[MINUPD_W-1:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				gm_q  <= gm_n;
				pos_q <= pos_n;
				lmt_q <= lmt_n;
				lm_q  <= lm_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q      <= item;
			elapsed_q <= item.now_ms - lmt_q;
			dq_q      <= item.now_ms - lmt_q;
			rem_q     <= '0;
		end else if (cmd.step) begin
			rem_q <= rem_ge ? DIVISOR_W'(rem_sh - {1'b0, div10_q}) : rem_sh[DIVISOR_W-1:0];
			dq_q  <= {dq_q[TIME_W-2:0], rem_ge};
		end
		// state is stable from load to commit, so the divisor can follow it
		div10_q <= div10;
		if (cmd.commit) begin
			res_q.gate_report      <= (gm_n == G_UNKNOWN) ? G_STOPPED : gm_n;
			res_q.position_pct     <= pos_n;
			res_q.state_publish    <= ps;
			res_q.position_publish <= pp;
			res_q.light_report     <= (lm_n == L_ON);
			res_q.light_publish    <= pl;
			res_q.relay_fire       <= relay;
			res_q.light_drive      <= drive;
		end
	end

	assign res = res_q;

endmodule

>>> rtl/gpt_ctrl.sv
// Controller: request handshakes and the divide sequence of the tracker.
// Depends on gpt_pkg; drives gpt_dp through command/status structs.
`timescale 1ns / 1ps

module gpt_ctrl import gpt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output gpt_cmd_t cmd,
	input  gpt_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = (state_q == ST_IDLE) && in_valid;
	assign cmd.step   = (state_q == ST_DIV);
	// result register frees up when the pending result is taken this cycle
	assign cmd.commit = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					cnt_q <= '0;
					state_q <= sts.needs_div ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/gate_position_tracker_top.sv
// Channel      | Dir | Handshake      | Payload
// in_ch        | in  | valid / ready  | mode, force_req, switches, light_sense, now_ms
// out_ch       | out | valid / ready  | gate/light reports, publish flags, relay, drive
// cfg          | in  | cfg_we         | cfg_index, cfg_data (no read-back)
//
// A request passes IDLE, CHECK and DONE from accept to the next accept; a poll
// that finds the gate moving between the switches also passes DIV, where the
// 32-step restoring divider in gpt_dp (one quotient bit per cycle) runs.
// The result register lets a new request be accepted while a result waits;
// the next commit then stalls until out_ch.ready.
// Reset is asynchronous, active low; config returns to 13 s / 19 s / 200 ms.
`timescale 1ns / 1ps

module gate_position_tracker_top import gpt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	gpt_in_if.sink                in_ch,
	gpt_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	gpt_cmd_t cmd;
	gpt_sts_t sts;
	item_t    item;
	result_t  res;

	assign item.mode          = in_ch.mode;
	assign item.force_req     = in_ch.force_req;
	assign item.open_switch   = in_ch.open_switch;
	assign item.closed_switch = in_ch.closed_switch;
	assign item.light_sense   = in_ch.light_sense;
	assign item.now_ms        = in_ch.now_ms;

	gpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	gpt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.res       (res)
	);

	assign out_ch.gate_report      = res.gate_report;
	assign out_ch.position_pct     = res.position_pct;
	assign out_ch.state_publish    = res.state_publish;
	assign out_ch.position_publish = res.position_publish;
	assign out_ch.light_report     = res.light_report;
	assign out_ch.light_publish    = res.light_publish;
	assign out_ch.relay_fire       = res.relay_fire;
	assign out_ch.light_drive      = res.light_drive;

endmodule

>>> rtl/gpt_checker.sv
// Port-level checks of the gate position tracker, bound to the top level.
// Depends on gpt_pkg and gate_position_tracker_top_macros.svh.
`timescale 1ns / 1ps
`include "gate_position_tracker_top_macros.svh"

module gpt_checker import gpt_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [2:0]       gate_report,
	input logic [POS_W-1:0] position_pct,
	input logic             state_publish,
	input logic             position_publish,
	input logic             light_report,
	input logic             light_publish,
	input logic [1:0]       relay_fire,
	input logic [1:0]       light_drive
);

	result_t out_payload;

	assign out_payload = {gate_report, position_pct, state_publish, position_publish,
		light_report, light_publish, relay_fire, light_drive};

	// stalled result holds
	`GPT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_payload))
	`GPT_ASSERT_IMP(a_pos_range, clk, arst_n, out_valid, position_pct <= POS_FULL)
	// any relay command either sets motion or resyncs; both publish state
	`GPT_ASSERT_IMP(a_relay_state, clk, arst_n, out_valid && relay_fire != RELAY_NONE, state_publish)
	`GPT_ASSERT_IMP(a_light_drive, clk, arst_n, out_valid && light_drive != DRIVE_NONE, light_publish && (light_report == (light_drive == DRIVE_ON)))
	// one request at a time
	`GPT_ASSERT_NXT(a_one_inflight, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind gate_position_tracker_top gpt_checker u_gpt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.gate_report      (out_ch.gate_report),
	.position_pct     (out_ch.position_pct),
	.state_publish    (out_ch.state_publish),
	.position_publish (out_ch.position_publish),
	.light_report     (out_ch.light_report),
	.light_publish    (out_ch.light_publish),
	.relay_fire       (out_ch.relay_fire),
	.light_drive      (out_ch.light_drive)
);

>>> bench/tb_gate_position_tracker_top.sv
// Self-checking bench for gate_position_tracker_top: directed table, then random phases.
// Depends on gpt_pkg and the gpt_in_if / gpt_out_if channel interfaces of the RTL.
`timescale 1ns / 1ps

module tb_gate_position_tracker_top;
	import gpt_pkg::*;

	localparam int CYCLE_LIMIT     = 600000;
	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int HOLD_CYCLES     = 300;
	localparam int TAIL_CYCLES     = 60;

	// mode codes with no function in the block
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	typedef enum logic [1:0] {
		PINS_AT_OPEN,
		PINS_AT_CLOSED,
		PINS_MIDWAY
	} pins_t;

	typedef struct packed {
		item_t   it;
		logic    typed;
		result_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gpt_in_if in_ch ();
	gpt_out_if out_ch ();

	gate_position_tracker_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// tracker copy: gate, position, time mark, light, registers
	gate_mode_t g_mode;
	logic [POS_W-1:0] g_pos;
	logic [TIME_W-1:0] g_last;
	light_mode_t l_mode;
	logic [TRAVEL_W-1:0] up_sec;
	logic [TRAVEL_W-1:0] down_sec;
	logic [MINUPD_W-1:0] min_upd;
	logic pub_st, pub_ps, pub_lt;

	result_t pending_reports[$];
	dir_row_t dir_rows[$];

	int err_count = 0;
	int reports_checked = 0;
	int requests_sent = 0;
	int cycle_count = 0;
	bit long_hold_req = 0;

	logic [TIME_W-1:0] cur_ms;
	logic cur_sense;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_gate_position_tracker_top: done, errors");
			$finish;
		end
	end

	task automatic track_gate(input pins_t pins, input logic force_pub, input logic [TIME_W-1:0] now);
		gate_mode_t prev;
		logic [TIME_W-1:0] elapsed;
		longint unsigned secs, delta;
		prev = g_mode;
		pub_st = force_pub;
		pub_ps = force_pub;
		if (pins != PINS_MIDWAY) begin
			g_mode = (pins == PINS_AT_OPEN) ? G_OPEN : G_CLOSED;
			g_pos = (pins == PINS_AT_OPEN) ? POS_FULL : POS_ZERO;
			g_last = now;
			pub_st = force_pub || (prev != g_mode);
			pub_ps = force_pub || pub_st;
		end else begin
			if (g_mode == G_OPEN || g_mode == G_OPENING)
				g_mode = G_OPENING;
			else if (g_mode == G_CLOSED || g_mode == G_CLOSING)
				g_mode = G_CLOSING;
			else if (g_mode == G_UNKNOWN)
				g_mode = G_STOPPED;
			if (g_mode == G_OPENING || g_mode == G_CLOSING) begin
				elapsed = now - g_last;
				if (elapsed >= min_upd || force_pub) begin
					secs = (g_mode == G_OPENING) ? up_sec : down_sec;
					if (secs == 0)
						secs = 1;
					delta = ({32'd0, elapsed} * 100) / (secs * 1000);
					if (delta > 0 || force_pub) begin
						if (g_mode == G_OPENING) begin
							if (delta + g_pos >= POS_FULL)
								g_pos = POS_FULL;
							else
								g_pos = g_pos + delta[POS_W-1:0];
						end else begin
							if (delta >= g_pos)
								g_pos = POS_ZERO;
							else
								g_pos = g_pos - delta[POS_W-1:0];
						end
						g_last = now;
						pub_ps = 1'b1;
					end
				end
			end
			pub_st = force_pub || (prev != g_mode);
		end
	endtask

	task automatic track_light(input logic sense, input logic force_pub);
		light_mode_t prev;
		prev = l_mode;
		l_mode = sense ? L_ON : L_OFF;
		pub_lt = force_pub || (prev != l_mode);
	endtask

	// advances the tracker copy by one request and forms its report
	task automatic track_request(input item_t it, output result_t rep);
		pins_t pins;
		logic [1:0] relay, drive;
		pub_st = 1'b0;
		pub_ps = 1'b0;
		pub_lt = 1'b0;
		relay = RELAY_NONE;
		drive = DRIVE_NONE;
		if (!it.open_switch && it.closed_switch)
			pins = PINS_AT_OPEN;
		else if (it.open_switch && !it.closed_switch)
			pins = PINS_AT_CLOSED;
		else
			pins = PINS_MIDWAY;
		case (mode_t'(it.mode))
			MODE_POLL: begin
				track_gate(pins, it.force_req, it.now_ms);
				track_light(it.light_sense, it.force_req);
			end
			MODE_OPEN, MODE_CLOSE, MODE_STOP: begin
				if (it.mode == MODE_OPEN)
					relay = RELAY_OPEN;
				else if (it.mode == MODE_CLOSE)
					relay = RELAY_CLOSE;
				else
					relay = RELAY_STOP;
				if (pins == PINS_MIDWAY) begin
					if (it.mode == MODE_OPEN) begin
						g_mode = G_OPENING;
						g_last = it.now_ms;
					end else if (it.mode == MODE_CLOSE) begin
						g_mode = G_CLOSING;
						g_last = it.now_ms;
					end else begin
						g_mode = G_STOPPED;
					end
					pub_st = 1'b1;
				end else begin
					track_gate(pins, 1'b1, it.now_ms);
					track_light(it.light_sense, 1'b1);
				end
			end
			MODE_LIGHT_ON, MODE_LIGHT_OFF: begin
				drive = (it.mode == MODE_LIGHT_ON) ? DRIVE_ON : DRIVE_OFF;
				l_mode = (it.mode == MODE_LIGHT_ON) ? L_ON : L_OFF;
				pub_lt = 1'b1;
			end
			default: ;
		endcase
		rep.gate_report = (g_mode == G_UNKNOWN) ? G_STOPPED : g_mode;
		rep.position_pct = g_pos;
		rep.state_publish = pub_st;
		rep.position_publish = pub_ps;
		rep.light_report = (l_mode == L_ON);
		rep.light_publish = pub_lt;
		rep.relay_fire = relay;
		rep.light_drive = drive;
	endtask

	// offer one request, hold until taken, queue its report
	task automatic send_request(input item_t it, input logic typed, input result_t want);
		result_t rep;
		in_ch.valid <= 1'b1;
		in_ch.mode <= it.mode;
		in_ch.force_req <= it.force_req;
		in_ch.open_switch <= it.open_switch;
		in_ch.closed_switch <= it.closed_switch;
		in_ch.light_sense <= it.light_sense;
		in_ch.now_ms <= it.now_ms;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		track_request(it, rep);
		pending_reports.push_back(typed ? want : rep);
		requests_sent++;
	endtask

	task automatic idle_sender(input int n);
		if (n > 0) begin
			in_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_for_reports();
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 4);
		else if (r < 97)
			return $urandom_range(5, 20);
		return $urandom_range(30, 80);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_UP_TRAVEL: up_sec = data[TRAVEL_W-1:0];
			REG_DOWN_TRAVEL: down_sec = data[TRAVEL_W-1:0];
			REG_MIN_UPDATE: min_upd = data[MINUPD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input int ph);
		logic [CFG_DATA_W-1:0] u, d, m;
		case (ph)
			1: begin u = 16'hFF01; d = 16'h0001; m = 16'h0000; end
			2: begin u = 16'h00FF; d = 16'hFFFF; m = 16'hFFFF; end
			3: begin u = 16'h0000; d = 16'hFF00; m = $urandom_range(0, 1000); end
			4: begin
				u = $urandom_range(0, 65535);
				d = $urandom_range(0, 65535);
				m = $urandom_range(0, 65535);
			end
			default: begin
				u = $urandom_range(0, 65535);
				d = $urandom_range(0, 65535);
				m = $urandom_range(0, 400);
			end
		endcase
		write_reg(REG_UP_TRAVEL, u);
		write_reg(REG_DOWN_TRAVEL, d);
		write_reg(REG_MIN_UPDATE, m);
		cfg_we <= 1'b0;
	endtask

	// mostly a plausible gate history; a small share of raw noise
	task automatic make_random_item(output item_t it);
		int r;
		if ($urandom_range(0, 99) < 8) begin
			it.mode = $urandom_range(0, 7);
			it.force_req = $urandom_range(0, 1);
			it.open_switch = $urandom_range(0, 1);
			it.closed_switch = $urandom_range(0, 1);
			it.light_sense = $urandom_range(0, 1);
			it.now_ms = $urandom;
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			it.mode = MODE_POLL;
		else if (r < 67)
			it.mode = MODE_OPEN;
		else if (r < 79)
			it.mode = MODE_CLOSE;
		else if (r < 87)
			it.mode = MODE_STOP;
		else if (r < 93)
			it.mode = MODE_LIGHT_ON;
		else
			it.mode = MODE_LIGHT_OFF;
		it.force_req = ($urandom_range(0, 99) < 15);
		r = $urandom_range(0, 99);
		if (r < 58) begin
			it.open_switch = 1'b0;
			it.closed_switch = 1'b0;
		end else if (r < 72) begin
			it.open_switch = 1'b1;
			it.closed_switch = 1'b1;
		end else if (r < 86) begin
			it.open_switch = 1'b0;
			it.closed_switch = 1'b1;
		end else begin
			it.open_switch = 1'b1;
			it.closed_switch = 1'b0;
		end
		if ($urandom_range(0, 99) < 20)
			cur_sense = ~cur_sense;
		it.light_sense = cur_sense;
		r = $urandom_range(0, 99);
		if (r < 50)
			cur_ms = cur_ms + $urandom_range(0, 400);
		else if (r < 80)
			cur_ms = cur_ms + $urandom_range(0, 5000);
		else if (r < 96)
			cur_ms = cur_ms + $urandom_range(0, 60000);
		else
			cur_ms = $urandom;
		it.now_ms = cur_ms;
	endtask

	task automatic add_row(input logic [2:0] mode, input logic f, input logic op, input logic cl,
		input logic s, input logic [TIME_W-1:0] now, input logic typed, input result_t want);
		dir_row_t row;
		row.it.mode = mode;
		row.it.force_req = f;
		row.it.open_switch = op;
		row.it.closed_switch = cl;
		row.it.light_sense = s;
		row.it.now_ms = now;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	// result checker
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.gate_report, out_ch.position_pct, out_ch.state_publish,
				out_ch.position_publish, out_ch.light_report, out_ch.light_publish,
				out_ch.relay_fire, out_ch.light_drive};
			if (pending_reports.size() == 0) begin
				$error("report with no request outstanding: %p", got);
				err_count++;
			end else begin
				want = pending_reports.pop_front();
				reports_checked++;
				if (got.gate_report !== want.gate_report) begin
					$error("gate_report: expected %0d, got %0d", want.gate_report, got.gate_report);
					err_count++;
				end
				if (got.position_pct !== want.position_pct) begin
					$error("position_pct: expected %0d, got %0d", want.position_pct,
						got.position_pct);
					err_count++;
				end
				if (got.state_publish !== want.state_publish) begin
					$error("state_publish: expected %0d, got %0d", want.state_publish,
						got.state_publish);
					err_count++;
				end
				if (got.position_publish !== want.position_publish) begin
					$error("position_publish: expected %0d, got %0d", want.position_publish,
						got.position_publish);
					err_count++;
				end
				if (got.light_report !== want.light_report) begin
					$error("light_report: expected %0d, got %0d", want.light_report,
						got.light_report);
					err_count++;
				end
				if (got.light_publish !== want.light_publish) begin
					$error("light_publish: expected %0d, got %0d", want.light_publish,
						got.light_publish);
					err_count++;
				end
				if (got.relay_fire !== want.relay_fire) begin
					$error("relay_fire: expected %0d, got %0d", want.relay_fire, got.relay_fire);
					err_count++;
				end
				if (got.light_drive !== want.light_drive) begin
					$error("light_drive: expected %0d, got %0d", want.light_drive,
						got.light_drive);
					err_count++;
				end
			end
		end
	end

	// receiver: random back-pressure, one long hold-off on request
	initial begin
		int r;
		out_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold_req = 0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_ch.ready <= 1'b1;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end else if (r < 88) begin
					out_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else if (r < 95) begin
					out_ch.ready <= 1'b0;
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end else begin
					out_ch.ready <= 1'b1;
					repeat ($urandom_range(50, 150)) @(posedge clk);
				end
			end
		end
	end

	initial begin
		item_t it;
		int sent, burst, n_dir;
		bit counted;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_UP_TRAVEL;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_POLL;
		in_ch.force_req = 1'b0;
		in_ch.open_switch = 1'b0;
		in_ch.closed_switch = 1'b0;
		in_ch.light_sense = 1'b0;
		in_ch.now_ms = '0;
		g_mode = G_UNKNOWN;
		g_pos = POS_ZERO;
		g_last = '0;
		l_mode = L_UNKNOWN;
		up_sec = UP_TRAVEL_RST;
		down_sec = DOWN_TRAVEL_RST;
		min_upd = MIN_UPDATE_RST;
		cur_ms = '0;
		cur_sense = 1'b0;

		// first poll after reset, unused mode, light commands, first sync,
		// then travel, saturation, timestamp wrap, commands at the switches
		add_row(MODE_POLL, 0, 1, 1, 0, 32'd0, 1,
			'{G_STOPPED, POS_ZERO, 1'b1, 1'b0, 1'b0, 1'b1, RELAY_NONE, DRIVE_NONE});
		add_row(MODE_SPARE_6, 1, 0, 1, 1, 32'd5, 1,
			'{G_STOPPED, POS_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, RELAY_NONE, DRIVE_NONE});
		add_row(MODE_LIGHT_ON, 1, 1, 0, 0, 32'd10, 1,
			'{G_STOPPED, POS_ZERO, 1'b0, 1'b0, 1'b1, 1'b1, RELAY_NONE, DRIVE_ON});
		add_row(MODE_LIGHT_OFF, 0, 0, 0, 1, 32'd20, 1,
			'{G_STOPPED, POS_ZERO, 1'b0, 1'b0, 1'b0, 1'b1, RELAY_NONE, DRIVE_OFF});
		add_row(MODE_POLL, 0, 1, 0, 1, 32'd100, 1,
			'{G_CLOSED, POS_ZERO, 1'b1, 1'b1, 1'b1, 1'b1, RELAY_NONE, DRIVE_NONE});
		add_row(MODE_OPEN, 0, 0, 0, 1, 32'd1000, 1,
			'{G_OPENING, POS_ZERO, 1'b1, 1'b0, 1'b1, 1'b0, RELAY_OPEN, DRIVE_NONE});
		add_row(MODE_POLL, 0, 0, 0, 1, 32'd1100, 0, '0);
		add_row(MODE_POLL, 0, 0, 0, 1, 32'd7500, 0, '0);
		add_row(MODE_POLL, 1, 0, 0, 1, 32'd7501, 0, '0);
		add_row(MODE_POLL, 0, 0, 1, 0, 32'd20000, 0, '0);
		add_row(MODE_CLOSE, 1, 0, 1, 0, 32'd20010, 0, '0);
		add_row(MODE_CLOSE, 0, 1, 1, 0, 32'd20020, 0, '0);
		add_row(MODE_POLL, 0, 1, 1, 1, 32'd30000, 0, '0);
		add_row(MODE_STOP, 0, 0, 0, 1, 32'd31000, 0, '0);
		add_row(MODE_POLL, 1, 0, 0, 0, 32'd60000, 0, '0);
		add_row(MODE_OPEN, 0, 1, 0, 0, 32'd60010, 0, '0);
		add_row(MODE_OPEN, 0, 0, 0, 1, 32'hFFFF_F000, 0, '0);
		add_row(MODE_POLL, 0, 1, 1, 1, 32'h0000_2000, 0, '0);
		add_row(MODE_POLL, 0, 0, 0, 1, 32'hFFFF_FFFF, 0, '0);
		add_row(MODE_SPARE_7, 1, 1, 1, 1, 32'hFFFF_FFFF, 0, '0);
		add_row(MODE_STOP, 1, 1, 0, 0, 32'd100, 0, '0);
		add_row(MODE_LIGHT_ON, 0, 1, 1, 0, 32'd200, 0, '0);
		add_row(MODE_POLL, 1, 1, 1, 1, 32'h8000_0000, 0, '0);
		n_dir = dir_rows.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
			idle_sender(pick_gap());
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				in_ch.valid <= 1'b0;
				wait_for_reports();
				load_settings(ph);
			end
			sent = 0;
			burst = 0;
			while (sent < ITEMS_PER_PHASE) begin
				make_random_item(it);
				// fill the block while the receiver holds off
				if (ph == 2 && sent == 20 && burst == 0 && !long_hold_req) begin
					long_hold_req = 1;
					burst = 40;
				end
				send_request(it, 1'b0, '0);
				counted = (it.mode <= MODE_LIGHT_OFF);
				if (counted)
					sent++;
				if (burst > 0) begin
					burst--;
				end else if (ph == 4 && sent == 50 && counted) begin
					in_ch.valid <= 1'b0;
					wait_for_reports();
				end else begin
					idle_sender(pick_gap());
				end
			end
		end

		in_ch.valid <= 1'b0;
		wait_for_reports();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d requests (%0d from the table) over %0d register settings, %0d reports",
			requests_sent, n_dir, NUM_PHASES, reports_checked);
		if (err_count == 0)
			$display("tb_gate_position_tracker_top: done, clean");
		else
			$display("tb_gate_position_tracker_top: done, errors");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/gpt_pkg.sv
rtl/gpt_if.sv
rtl/gpt_dp.sv
rtl/gpt_ctrl.sv
rtl/gate_position_tracker_top.sv
rtl/gpt_checker.sv
bench/tb_gate_position_tracker_top.sv
